// ----- hdl/cwmr_pkg.sv -----
// Package for the cell window mean reporter: sizes, payload structs, state codes.
// Used by cwmr_divider and cell_window_mean_reporter; depends on nothing.
`default_nettype none

package cwmr_pkg;

   localparam int MODULE_COUNT = 16;
   localparam int CELLS_EACH   = 8;
   localparam int CELL_TOTAL   = MODULE_COUNT * CELLS_EACH;
   localparam int CELL_IDX_W   = $clog2(CELL_TOTAL);
   localparam int MOD_IDX_W    = $clog2(MODULE_COUNT);

   localparam int MV_W         = 13;   // band limits and accepted readings
   localparam int SUM_W        = 29;
   localparam int COUNT_W      = 16;
   localparam int MEAN_W       = 14;   // quotient bits; a mean never exceeds 8191
   localparam int DIVIDEND_W   = SUM_W + 1;
   localparam int TOTAL_W      = 17;
   localparam int VALUE_W      = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [MEAN_W-1:0]  MEAN_NEVER = '1;  // no real mean reaches this

   localparam logic [MV_W-1:0] VALID_LOW_RESET  = MV_W'(1500);
   localparam logic [MV_W-1:0] VALID_HIGH_RESET = MV_W'(4500);

   localparam logic REG_VALID_LOW  = 1'b0;
   localparam logic REG_VALID_HIGH = 1'b1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLOSE  = 1'b1;

   localparam logic REPORT_CELL   = 1'b0;
   localparam logic REPORT_MODULE = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [3:0]         module_index;
      logic [2:0]         cell_index;
      logic signed [15:0] reading_mv;
      logic               module_present;
      logic               force_report;
   } req_type;

   typedef struct packed {
      logic               report_kind;
      logic [3:0]         report_module;
      logic [2:0]         report_cell;
      logic [VALUE_W-1:0] value_mv;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
      logic [MEAN_W-1:0]  last_mean;
   } cell_row_type;

   localparam cell_row_type CELL_ROW_RESET = '{sum: '0, count: '0, last_mean: MEAN_NEVER};

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [COUNT_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [MEAN_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_CELL_RPT,
      ST_MOD_CHK,
      ST_MOD_RPT
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/cwmr_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the rounded cell mean.
// Depends on cwmr_pkg for widths and the request and response structs.
`default_nettype none

module cwmr_divider
   import cwmr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   // The caller guarantees dividend < divisor * 2**MEAN_W, so the upper
   // dividend bits start as a partial remainder already below the divisor.
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [$clog2(MEAN_W)-1:0] step_ff, step_in;
   logic [COUNT_W-1:0]       rem_ff, rem_in;
   logic [MEAN_W-1:0]        dvd_ff, dvd_in;
   logic [MEAN_W-1:0]        quo_ff, quo_in;
   logic [COUNT_W-1:0]       dsr_ff, dsr_in;
   logic [COUNT_W:0]         trial;
   logic                     fits;

   always_comb begin
      trial   = {rem_ff, dvd_ff[MEAN_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = ($clog2(MEAN_W))'(MEAN_W - 1);
         rem_in  = div_req.dividend[DIVIDEND_W-1:MEAN_W];
         dvd_in  = div_req.dividend[MEAN_W-1:0];
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? COUNT_W'(trial - {1'b0, dsr_ff}) : trial[COUNT_W-1:0];
         dvd_in = {dvd_ff[MEAN_W-2:0], 1'b0};
         quo_in = {quo_ff[MEAN_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ----- hdl/cell_window_mean_reporter.sv -----
// A sample beat is accepted, then ST_READ does the read-modify-write of its row.
// A close beat divides in ST_DIVIDE unless its cell is empty, then takes one state for
// each report it makes, waiting for a free output, or for the module check.
// Throughput: one input beat at a time; the next beat is taken once the last is done.
// Reset (synchronous, active high) clears the per-row valid bits; no clearing pass.
// Top level of the cell window mean reporter; uses cwmr_pkg and cwmr_divider.
`default_nettype none

module cell_window_mean_reporter
   import cwmr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_type         req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp_data,
   input  wire logic            csr_we,
   input  wire logic            csr_index,
   input  wire logic [MV_W-1:0] csr_wdata
);

   // All per-cell state (running sum, sample count and the last reported mean)
   // lives in one row of the cell memory. A row whose valid bit is clear reads as
   // the reset row: empty window, mean never reported. The second memory keeps
   // the last module voltage reported for each module, with its own valid bits.
   // Only one beat is in flight, and its write-back lands before the next beat's
   // read is issued, so no forwarding path is needed.

   logic [MV_W-1:0] valid_low_ff, valid_high_ff;

   cell_row_type              cell_mem [CELL_TOTAL];
   logic [CELL_TOTAL-1:0]     cell_vld_ff;
   cell_row_type              cell_rd_ff;
   logic                      cell_seen_ff;
   logic                      cell_we;
   cell_row_type              cell_wdata;

   logic [TOTAL_W-1:0]        mod_mem [MODULE_COUNT];
   logic [MODULE_COUNT-1:0]   mod_vld_ff;
   logic [TOTAL_W-1:0]        mod_rd_ff;
   logic                      mod_seen_ff;
   logic                      mod_we;

   state_type                 state_ff, state_in;
   req_type                   item_ff;
   logic [CELL_IDX_W-1:0]     idx_ff;
   logic [CELL_IDX_W-1:0]     req_idx;
   logic [MOD_IDX_W-1:0]      item_mod;
   logic                      req_accept;
   logic                      in_range;

   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic                      complete_ff, complete_in;
   logic [MEAN_W-1:0]         mean_ff, mean_in;

   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff, rsp_data_in;
   logic                      rsp_load;

   div_req_type               div_req;
   div_rsp_type               div_rsp;

   cell_row_type              cell_row;
   logic [15:0]               raw;
   logic                      sample_ok;
   logic                      cell_rpt_due;
   logic                      mod_rpt_due;
   logic                      out_free;
   logic [TOTAL_W:0]          total_sum;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_low_ff  <= VALID_LOW_RESET;
         valid_high_ff <= VALID_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_VALID_LOW:  valid_low_ff  <= csr_wdata;
            REG_VALID_HIGH: valid_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign in_range   = (int'(req_data.module_index) < MODULE_COUNT) &&
                       (int'(req_data.cell_index) < CELLS_EACH);
   assign req_idx    = CELL_IDX_W'(int'(req_data.module_index) * CELLS_EACH +
                                   int'(req_data.cell_index));
   assign item_mod   = item_ff.module_index[MOD_IDX_W-1:0];

   // Cell memory: registered read on accept, write-back later in the beat.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cell_rd_ff   <= cell_mem[req_idx];
         cell_seen_ff <= cell_vld_ff[req_idx];
      end
      if (cell_we) begin
         cell_mem[idx_ff] <= cell_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= '0;
      end else if (cell_we) begin
         cell_vld_ff[idx_ff] <= 1'b1;
      end
   end

   // Module voltage memory.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mod_rd_ff   <= mod_mem[req_data.module_index[MOD_IDX_W-1:0]];
         mod_seen_ff <= mod_vld_ff[req_data.module_index[MOD_IDX_W-1:0]];
      end
      if (mod_we) begin
         mod_mem[item_mod] <= total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_vld_ff <= '0;
      end else if (mod_we) begin
         mod_vld_ff[item_mod] <= 1'b1;
      end
   end

   cwmr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign cell_row = cell_seen_ff ? cell_rd_ff : CELL_ROW_RESET;
   assign raw      = item_ff.reading_mv;

   // A negative reading has bit 15 set and can never fall inside the band.
   assign sample_ok = item_ff.module_present && !raw[15] &&
                      (raw >= {3'b000, valid_low_ff}) &&
                      (raw <= {3'b000, valid_high_ff}) &&
                      (cell_row.count != COUNT_MAX);

   assign cell_rpt_due = item_ff.force_report || (div_rsp.quotient != cell_row.last_mean);

   // The module report is judged on the running total as it stands once this
   // cell has been folded in.
   assign mod_rpt_due = (int'(item_ff.cell_index) == CELLS_EACH - 1) && complete_ff &&
                        (item_ff.force_report || !mod_seen_ff || (total_ff != mod_rd_ff));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(div_rsp.quotient);

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      complete_in = complete_ff;
      mean_in     = mean_ff;
      cell_we     = 1'b0;
      cell_wdata  = cell_row;
      mod_we      = 1'b0;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {1'b0, cell_row.sum} + DIVIDEND_W'(cell_row.count >> 1);
      div_req.divisor  = cell_row.count;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && in_range) begin
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            if (item_ff.kind == KIND_SAMPLE) begin
               cell_we          = sample_ok;
               cell_wdata.sum   = cell_row.sum + SUM_W'(raw);
               cell_wdata.count = cell_row.count + 1'b1;
               state_in         = ST_IDLE;
            end else begin
               // Closing cell 0 opens a new run for the module.
               if (item_ff.cell_index == 3'd0) begin
                  total_in    = '0;
                  complete_in = 1'b1;
               end
               if (cell_row.count == '0) begin
                  complete_in      = 1'b0;
                  cell_we          = 1'b1;
                  cell_wdata.sum   = '0;
                  cell_wdata.count = '0;
                  state_in         = ST_MOD_CHK;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end

         ST_DIVIDE: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient;
               total_in = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                                                          : total_sum[TOTAL_W-1:0];
               // When no report is due the stored mean already equals this one.
               cell_we              = 1'b1;
               cell_wdata.sum       = '0;
               cell_wdata.count     = '0;
               cell_wdata.last_mean = div_rsp.quotient;
               state_in = cell_rpt_due ? ST_CELL_RPT : ST_MOD_CHK;
            end
         end

         ST_CELL_RPT: begin
            if (out_free) begin
               rsp_load                  = 1'b1;
               rsp_data_in.report_kind   = REPORT_CELL;
               rsp_data_in.report_module = item_ff.module_index;
               rsp_data_in.report_cell   = item_ff.cell_index;
               rsp_data_in.value_mv      = VALUE_W'(mean_ff);
               rsp_data_in.last_of_run   = !mod_rpt_due;
               state_in = mod_rpt_due ? ST_MOD_RPT : ST_IDLE;
            end
         end

         ST_MOD_CHK: begin
            state_in = mod_rpt_due ? ST_MOD_RPT : ST_IDLE;
         end

         ST_MOD_RPT: begin
            if (out_free) begin
               rsp_load                  = 1'b1;
               mod_we                    = 1'b1;
               rsp_data_in.report_kind   = REPORT_MODULE;
               rsp_data_in.report_module = item_ff.module_index;
               rsp_data_in.report_cell   = 3'd0;
               rsp_data_in.value_mv      = VALUE_W'(total_ff);
               rsp_data_in.last_of_run   = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         complete_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         total_ff    <= total_in;
         complete_ff <= complete_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         item_ff <= req_data;
         idx_ff  <= req_idx;
      end
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for cell_window_mean_reporter: drives sample and close beats and predicts
// the cell and module reports. Each report beat is checked against that prediction.
// Depends on cwmr_pkg and the block itself; reads no files.

module tb_top;
   import cwmr_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 5;
   // Long enough for any beat that is still in flight after the last report has come out.
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int LIMIT_CYCLES   = 200_000;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_type         req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_type         rsp_data;
   logic            csr_we    = 1'b0;
   logic            csr_index = REG_VALID_LOW;
   logic [MV_W-1:0] csr_wdata = '0;

   cell_window_mean_reporter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The testbench keeps its own copy of the per-cell windows, the last values reported
   // and the running module total. The copy is advanced once for every accepted input beat.
   logic [SUM_W-1:0]   win_sum       [CELL_TOTAL];
   logic [COUNT_W-1:0] win_count     [CELL_TOTAL];
   int                 shown_mean    [CELL_TOTAL];    // -1 until a mean is reported
   int                 shown_voltage [MODULE_COUNT];  // -1 until a voltage is reported
   logic [TOTAL_W-1:0] run_total;
   bit                 run_complete;
   logic [MV_W-1:0]    band_low;
   logic [MV_W-1:0]    band_high;

   req_type beats_to_send [$];  // filled by the stimulus, drained by the driver
   rsp_type reports_due   [$];  // predicted reports, oldest first

   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   bit     pressure_on   = 1'b0;
   int     hold_count    = 0;
   int     beats_taken   = 0;
   int     closes_taken  = 0;
   int     reports_seen  = 0;
   int     band_settings = 0;
   int     mismatches    = 0;
   longint cycle_count   = 0;

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // Advances the window copy by one beat and queues the reports that the beat causes.
   // A sample only updates its cell. A close empties the cell; if the cell held samples it
   // first forms the rounded mean and adds it to the running total. On the last cell it may
   // also report the module voltage.
   function automatic void predict_reports(req_type b);
      int          slot;
      logic [15:0] raw;
      longint      mean;
      longint      total;
      rsp_type     made [$];
      rsp_type     r;
      slot = int'(b.module_index) * CELLS_EACH + int'(b.cell_index);
      if (b.kind == KIND_SAMPLE) begin
         raw = b.reading_mv;
         // A negative reading has bit 15 set, so it can never fall inside the band.
         if (b.module_present && !raw[15] && raw >= band_low && raw <= band_high &&
             win_count[slot] != COUNT_MAX) begin
            win_sum[slot]   = win_sum[slot] + SUM_W'(raw);
            win_count[slot] = win_count[slot] + 1'b1;
         end
         return;
      end
      // Closing cell 0 starts a new module run. Any other close carries on from whatever
      // the previous close left behind.
      if (b.cell_index == 0) begin
         run_total    = '0;
         run_complete = 1'b1;
      end
      if (win_count[slot] == 0) begin
         run_complete = 1'b0;
      end else begin
         mean  = (longint'(win_sum[slot]) + win_count[slot] / 2) / win_count[slot];
         total = longint'(run_total) + mean;
         run_total = (total > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(total);
         if (b.force_report || mean != shown_mean[slot]) begin
            r               = '0;
            r.report_kind   = REPORT_CELL;
            r.report_module = b.module_index;
            r.report_cell   = b.cell_index;
            r.value_mv      = VALUE_W'(mean);
            made.push_back(r);
            shown_mean[slot] = int'(mean);
         end
      end
      win_sum[slot]   = '0;
      win_count[slot] = '0;
      if (b.cell_index == CELLS_EACH - 1 && run_complete &&
          (b.force_report || int'(run_total) != shown_voltage[b.module_index])) begin
         r               = '0;
         r.report_kind   = REPORT_MODULE;
         r.report_module = b.module_index;
         r.value_mv      = VALUE_W'(run_total);
         made.push_back(r);
         shown_voltage[b.module_index] = int'(run_total);
      end
      if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
      foreach (made[i]) reports_due.push_back(made[i]);
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("report field %s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_report(rsp_type got);
      rsp_type want;
      reports_seen++;
      if (reports_due.size() == 0) begin
         $error("report beat for module %0d cell %0d arrived with none predicted",
                got.report_module, got.report_cell);
         mismatches++;
         return;
      end
      want = reports_due.pop_front();
      compare_field("report_kind",   32'(want.report_kind),   32'(got.report_kind));
      compare_field("report_module", 32'(want.report_module), 32'(got.report_module));
      compare_field("report_cell",   32'(want.report_cell),   32'(got.report_cell));
      compare_field("value_mv",      32'(want.value_mv),      32'(got.value_mv));
      compare_field("last_of_run",   32'(want.last_of_run),   32'(got.last_of_run));
   endtask

   // Input driver. A beat counts as accepted at the edge where valid and ready are both
   // high. It is predicted right then, so the band copy always matches the band in force.
   // Once a beat is offered, valid stays up with the same payload until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_reports(req_data);
            beats_taken++;
            if (req_data.kind == KIND_CLOSE) closes_taken++;
         end
         if (!req_valid || req_ready) begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= beats_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Report monitor. While a pressure phase is active, ready stays low until hold_count
   // reaches HOLD_CYCLES, so the block has to stall its input behind a held report.
   // Otherwise ready toggles at the current idle rate.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_report(rsp_data);
         if (pressure_on && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            rsp_ready  <= 1'b0;
         end else begin
            if (!pressure_on) hold_count <= 0;
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d reports outstanding.",
                  cycle_count, reports_due.size());
         $display("cell_window_mean_reporter test failed");
         $finish;
      end
   end

   function automatic req_type make_beat(logic kind, int module_no, int cell_no,
                                         int reading, logic present, logic force_rpt);
      req_type b;
      b                = '0;
      b.kind           = kind;
      b.module_index   = 4'(module_no);
      b.cell_index     = 3'(cell_no);
      b.reading_mv     = 16'(reading);
      b.module_present = present;
      b.force_report   = force_rpt;
      return b;
   endfunction

   // Chooses a reading for a sample. Steady readings are fixed per cell unless the band is
   // inverted, so a repeated window gives the same mean again and the unchanged-value
   // suppression is exercised. About one reading in ten is an arbitrary 16-bit pattern.
   function automatic int pick_reading(int slot, bit steady, bit run_high);
      int span;
      span = int'(band_high) - int'(band_low);
      if (run_high) return $urandom_range(8091, 8191);
      if (span < 0) return $urandom_range(8191);
      if (steady) return int'(band_low) + (slot * 37 + 11) % (span + 1);
      if ($urandom_range(9) == 0) return $urandom_range(65535);
      return int'(band_low) + $urandom_range(span);
   endfunction

   // Queues one window: a few samples for each cell from first_cell up, each cell followed
   // by its close. Ordinary windows sometimes leave a cell empty or send from an absent
   // module. Steady and high windows always fill every cell from a present module.
   task automatic queue_window(int module_no, int first_cell, bit steady, bit run_high,
                               inout int counted);
      int cell_no;
      int samples;
      int slot;
      bit present;
      for (cell_no = first_cell; cell_no < CELLS_EACH; cell_no++) begin
         slot = module_no * CELLS_EACH + cell_no;
         if (steady || run_high)          samples = $urandom_range(1, 3);
         else if ($urandom_range(9) == 0) samples = 0;
         else                             samples = $urandom_range(1, 3);
         repeat (samples) begin
            present = steady || run_high || ($urandom_range(19) != 0);
            beats_to_send.push_back(make_beat(KIND_SAMPLE, module_no, cell_no,
                                              pick_reading(slot, steady, run_high),
                                              present, 1'($urandom_range(1))));
            if (present) counted++;
         end
         beats_to_send.push_back(make_beat(KIND_CLOSE, module_no, cell_no, $urandom(),
                                           1'($urandom_range(1)), $urandom_range(7) == 0));
         counted++;
      end
   endtask

   // Waits until every beat has been taken and every predicted report has arrived.
   // It then lets a sample beat or a close without reports that is still in progress finish.
   task automatic wait_quiet();
      while (beats_to_send.size() != 0 || req_valid || reports_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both band registers, only while the block is quiet.
   task automatic write_band(logic [MV_W-1:0] low, logic [MV_W-1:0] high);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_VALID_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= REG_VALID_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_we    <= 1'b0;
      band_low  = low;
      band_high = high;
      band_settings++;
   endtask

   // One random phase under a single band setting and idle pattern. Most of the traffic is
   // well-formed windows that start at cell 0. The rest is windows that start part way
   // through the module and single beats with every field random. The overflow chain runs
   // several high-valued windows that skip cell 0, so the running total saturates.
   task automatic run_phase(logic [MV_W-1:0] low, logic [MV_W-1:0] high, int send_pct,
                            int recv_pct, int beats, bit hold, bit overflow_chain);
      int counted;
      int roll;
      counted = 0;
      wait_quiet();
      write_band(low, high);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      pressure_on   = hold;
      if (overflow_chain) begin
         repeat (4) queue_window($urandom_range(15), 1, 1'b0, 1'b1, counted);
      end
      while (counted < beats) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            beats_to_send.push_back(make_beat(1'($urandom_range(1)), $urandom_range(15),
                                              $urandom_range(7), $urandom(),
                                              1'($urandom_range(1)),
                                              1'($urandom_range(1))));
            counted++;
         end else if (roll < 25) begin
            queue_window($urandom_range(15), $urandom_range(1, 7), 1'b0, 1'b0, counted);
         end else if (roll < 45) begin
            // Steady windows go to modules 0 and 1 so they repeat often enough.
            queue_window($urandom_range(1), 0, 1'b1, 1'b0, counted);
         end else begin
            queue_window($urandom_range(15), 0, 1'b0, 1'b0, counted);
         end
      end
      wait_quiet();
      pressure_on = 1'b0;
   endtask

   initial begin
      int          cell_no;
      logic [12:0] mid_low;
      logic [12:0] mid_high;
      foreach (win_sum[i]) begin
         win_sum[i]    = '0;
         win_count[i]  = '0;
         shown_mean[i] = -1;
      end
      foreach (shown_voltage[i]) shown_voltage[i] = -1;
      run_total    = '0;
      run_complete = 1'b1;
      band_low     = VALID_LOW_RESET;
      band_high    = VALID_HIGH_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the band that reset leaves in place. The first group tests the
      // band edges, readings just outside the band, both extremes of the reading field and
      // a sample from an absent module. All of these go to module 0, cell 0.
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, 1500, 1'b1, 1'b0));
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, 4500, 1'b1, 1'b0));
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, 1499, 1'b1, 1'b0));
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, 4501, 1'b1, 1'b0));
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, -32768, 1'b1, 1'b0));
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, 32767, 1'b1, 1'b0));
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, 3000, 1'b0, 1'b1));
      beats_to_send.push_back(make_beat(KIND_CLOSE, 0, 0, 0, 1'b1, 1'b0));
      // A complete run over the last module gives one cell report per cell and a module
      // report at the end. Closing the last cell again while it is empty gives nothing.
      for (cell_no = 0; cell_no < CELLS_EACH; cell_no++) begin
         beats_to_send.push_back(make_beat(KIND_SAMPLE, 15, cell_no, 4000, 1'b1, 1'b0));
         beats_to_send.push_back(make_beat(KIND_CLOSE, 15, cell_no, 0, 1'b1, 1'b0));
      end
      beats_to_send.push_back(make_beat(KIND_CLOSE, 15, CELLS_EACH - 1, 0, 1'b1, 1'b0));
      // Forcing an unchanged mean still reports it.
      beats_to_send.push_back(make_beat(KIND_SAMPLE, 0, 0, 3000, 1'b1, 1'b0));
      beats_to_send.push_back(make_beat(KIND_CLOSE, 0, 0, 0, 1'b0, 1'b1));

      // The sender idles rarely and the receiver often.
      run_phase('0, '1, 7, 82, 120, 1'b0, 1'b1);
      run_phase(13'd3000, 13'd3100, 7, 82, 110, 1'b0, 1'b0);
      // Then the other way round, including an inverted band that accepts nothing.
      run_phase('1, '0, 82, 7, 60, 1'b0, 1'b0);
      run_phase(VALID_LOW_RESET, VALID_HIGH_RESET, 82, 7, 120, 1'b0, 1'b1);
      // Then no idling at all. The first of these phases opens with a long output stall.
      mid_low  = 13'($urandom_range(500, 3000));
      mid_high = mid_low + 13'($urandom_range(0, 4000));
      run_phase(mid_low, mid_high, 0, 0, 120, 1'b1, 1'b0);
      run_phase('0, '0, 0, 0, 60, 1'b0, 1'b0);
      run_phase('1, '1, 0, 0, 60, 1'b0, 1'b0);
      wait_quiet();

      $display("Covered %0d input beats (%0d window closes) over %0d band settings.",
               beats_taken, closes_taken, band_settings);
      $display("Checked %0d report beats, including a saturated total and a long stall.",
               reports_seen);
      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("cell_window_mean_reporter test passed");
      end else begin
         $display("cell_window_mean_reporter test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/cwmr_pkg.sv
hdl/cwmr_divider.sv
hdl/cell_window_mean_reporter.sv
tb/tb_top.sv
